// ===== rtl/core/sbspd_pkg.sv =====
`timescale 1ns / 1ps

package sbspd_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [7:0]  SYNC_FF    = 8'hff;
  localparam logic [7:0]  SYNC_FD    = 8'hfd;
  localparam logic [7:0]  SYNC_ZERO  = 8'h00;
  localparam logic [23:0] SYNC_HEAD  = {SYNC_FF, SYNC_FF, SYNC_FD};
  localparam logic [7:0]  ID_ANY     = 8'hfe;
  localparam logic [15:0] MIN_LENGTH = 16'd4;

  localparam logic [7:0]  EXPECTED_ID_RESET    = ID_ANY;
  localparam logic [15:0] EXPECTED_COUNT_RESET = 16'd0;

  typedef enum logic {
    CFG_EXPECTED_ID    = 1'b0,
    CFG_EXPECTED_COUNT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CRC_BAD   = 2'd1,
    STATUS_COUNT_BAD = 2'd2,
    STATUS_SHORT     = 2'd3
  } status_t;

  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  data_value;
    logic [7:0]  motor_id;
    logic [7:0]  instruction_code;
    logic [7:0]  device_error;
    status_t     status;
    logic [15:0] payload_count;
    logic        last;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  localparam logic [15:0] SYNC_CRC =
    crc_feed(crc_feed(crc_feed(crc_feed(16'h0000, SYNC_FF), SYNC_FF), SYNC_FD), SYNC_ZERO);

endpackage

// ===== rtl/core/sbspd_in_stage.sv =====
`timescale 1ns / 1ps

module sbspd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       step,
  output logic       full,
  output logic [7:0] byte_q
);

  assign in_ready = !full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (step) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/sbspd_parser.sv =====
`timescale 1ns / 1ps

module sbspd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_q,
  input  logic [7:0]        expected_id,
  input  logic [15:0]       expected_count,
  output logic              res_valid,
  output sbspd_pkg::result_t res
);

  import sbspd_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_ID, PH_LENLO, PH_LENHI, PH_INSTR, PH_ERR, PH_DATA, PH_CRCLO, PH_CRCHI
  } phase_t;

  phase_t      phase, phase_next;
  logic [23:0] sync_window, sync_window_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  length_lo, length_lo_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  packet_id, packet_id_next;
  logic [7:0]  instr_byte, instr_byte_next;
  logic [7:0]  err_byte, err_byte_next;
  logic [1:0]  escape_phase, escape_phase_next;
  logic [15:0] payload_total, payload_total_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic [15:0] crc_step;
  logic [15:0] length_full;
  logic        drop;
  status_t     verdict;

  assign crc_step    = crc_feed(running_crc, rx_q);
  assign length_full = {rx_q, length_lo};

  always_comb begin
    phase_next         = phase;
    sync_window_next   = sync_window;
    running_crc_next   = running_crc;
    length_lo_next     = length_lo;
    bytes_left_next    = bytes_left;
    packet_id_next     = packet_id;
    instr_byte_next    = instr_byte;
    err_byte_next      = err_byte;
    escape_phase_next  = escape_phase;
    payload_total_next = payload_total;
    crc_low_byte_next  = crc_low_byte;
    res_valid          = 1'b0;
    drop               = 1'b0;
    verdict            = STATUS_OK;

    case (phase)
      PH_HUNT: begin
        if (sync_window == SYNC_HEAD && rx_q == SYNC_ZERO) begin
          running_crc_next   = SYNC_CRC;
          packet_id_next     = 8'h00;
          instr_byte_next    = 8'h00;
          err_byte_next      = 8'h00;
          length_lo_next     = 8'h00;
          bytes_left_next    = 16'h0000;
          escape_phase_next  = 2'd0;
          payload_total_next = 16'h0000;
          crc_low_byte_next  = 8'h00;
          sync_window_next   = 24'h000000;
          phase_next         = PH_ID;
        end else begin
          sync_window_next = {sync_window[15:0], rx_q};
        end
      end
      PH_ID: begin
        if (expected_id != ID_ANY && rx_q != expected_id) begin
          sync_window_next = 24'h000000;
          phase_next       = PH_HUNT;
        end else begin
          packet_id_next   = rx_q;
          running_crc_next = crc_step;
          phase_next       = PH_LENLO;
        end
      end
      PH_LENLO: begin
        length_lo_next   = rx_q;
        running_crc_next = crc_step;
        phase_next       = PH_LENHI;
      end
      PH_LENHI: begin
        running_crc_next = crc_step;
        if (length_full < MIN_LENGTH) begin
          res_valid        = 1'b1;
          verdict          = STATUS_SHORT;
          sync_window_next = 24'h000000;
          phase_next       = PH_HUNT;
        end else begin
          bytes_left_next = length_full - MIN_LENGTH;
          phase_next      = PH_INSTR;
        end
      end
      PH_INSTR: begin
        instr_byte_next  = rx_q;
        running_crc_next = crc_step;
        phase_next       = PH_ERR;
      end
      PH_ERR: begin
        err_byte_next    = rx_q;
        running_crc_next = crc_step;
        phase_next       = (bytes_left == 16'h0000) ? PH_CRCLO : PH_DATA;
      end
      PH_DATA: begin
        running_crc_next = crc_step;
        if (escape_phase == 2'd0 && rx_q == SYNC_FF) begin
          escape_phase_next = 2'd1;
        end else if ((escape_phase == 2'd1 || escape_phase == 2'd2) && rx_q == SYNC_FF) begin
          escape_phase_next = 2'd2;
        end else if (escape_phase == 2'd2 && rx_q == SYNC_FD) begin
          escape_phase_next = 2'd3;
        end else if (escape_phase == 2'd3 && rx_q == SYNC_FD) begin
          escape_phase_next = 2'd0;
          drop              = 1'b1;
        end else begin
          escape_phase_next = (rx_q == SYNC_FF) ? 2'd1 : 2'd0;
        end
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left_next == 16'h0000) begin
          phase_next = PH_CRCLO;
        end
        if (!drop) begin
          payload_total_next = payload_total + 16'd1;
          res_valid          = 1'b1;
        end
      end
      PH_CRCLO: begin
        crc_low_byte_next = rx_q;
        phase_next        = PH_CRCHI;
      end
      PH_CRCHI: begin
        if ({rx_q, crc_low_byte} != running_crc) begin
          verdict = STATUS_CRC_BAD;
        end else if (payload_total != expected_count) begin
          verdict = STATUS_COUNT_BAD;
        end
        res_valid        = 1'b1;
        sync_window_next = 24'h000000;
        phase_next       = PH_HUNT;
      end
      default: begin
        sync_window_next = 24'h000000;
        phase_next       = PH_HUNT;
      end
    endcase

    res.item_kind        = (phase == PH_DATA) ? KIND_DATA : KIND_STATUS;
    res.data_value       = (phase == PH_DATA) ? rx_q : 8'h00;
    res.motor_id         = packet_id_next;
    res.instruction_code = instr_byte_next;
    res.device_error     = err_byte_next;
    res.status           = verdict;
    res.payload_count    = payload_total_next;
    res.last             = (phase != PH_DATA);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      sync_window   <= 24'h000000;
      running_crc   <= 16'h0000;
      length_lo     <= 8'h00;
      bytes_left    <= 16'h0000;
      packet_id     <= 8'h00;
      instr_byte    <= 8'h00;
      err_byte      <= 8'h00;
      escape_phase  <= 2'd0;
      payload_total <= 16'h0000;
      crc_low_byte  <= 8'h00;
    end else if (step) begin
      phase         <= phase_next;
      sync_window   <= sync_window_next;
      running_crc   <= running_crc_next;
      length_lo     <= length_lo_next;
      bytes_left    <= bytes_left_next;
      packet_id     <= packet_id_next;
      instr_byte    <= instr_byte_next;
      err_byte      <= err_byte_next;
      escape_phase  <= escape_phase_next;
      payload_total <= payload_total_next;
      crc_low_byte  <= crc_low_byte_next;
    end
  end

  a_short_has_no_payload: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STATUS_SHORT) |-> (res.payload_count == 16'h0000))
    else $error("short-length status carries payload count");

  a_data_item_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.item_kind == KIND_DATA) |-> (res.status == STATUS_OK && !res.last))
    else $error("payload item with status or last set");

  a_status_rehunts: assert property (@(posedge clk) disable iff (rst)
    (step && res_valid && res.item_kind == KIND_STATUS) |=> (phase == PH_HUNT))
    else $error("status item not followed by sync hunt");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_DATA && res_valid) |=> (payload_total == $past(payload_total) + 16'd1))
    else $error("payload count did not advance");

endmodule

// ===== rtl/core/sbspd_out_stage.sv =====
`timescale 1ns / 1ps

module sbspd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               res_valid,
  input  sbspd_pkg::result_t res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output sbspd_pkg::result_t out_q
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

endmodule

// ===== rtl/core/servo_bus_status_packet_deframer_core.sv =====
`timescale 1ns / 1ps
// Status-packet deframer for a byte-stuffed serial bus.
// Input channel: one received byte (rx_byte) per item on in_valid/in_ready.
// Output channel: payload bytes (item_kind 0) as they are unstuffed, then one
// status item (item_kind 1, last 1) with the CRC, count or length verdict; a
// consumer drops the packet's payload when status is not ok.
// Config channel: cfg_index 0 writes expected_id, 1 writes expected_count;
// always ready; the user writes only while the block is idle (not enforced).
// Path: an accepted byte waits in the input register; the parser turns it
// into its item, if any, which is registered in the output register when it has room.
// Throughput: one byte per cycle while the output register has room, set by the
// single parser stage and its byte-wide CRC update between the two registers.
// Stall: while the output item waits, one more byte is taken into the input
// register; in_ready then drops until out_ready frees the output register.
// Reset: both registers empty, parser hunting for sync, expected_id = 254
// (any id), expected_count = 0.

module servo_bus_status_packet_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [7:0]  data_value,
  output logic [7:0]  motor_id,
  output logic [7:0]  instruction_code,
  output logic [7:0]  device_error,
  output logic [1:0]  status,
  output logic [15:0] payload_count,
  output logic        last
);

  import sbspd_pkg::*;

  logic        in_full;
  logic [7:0]  rx_q;
  logic        room;
  logic        step;
  logic        res_valid;
  result_t     res;
  result_t     out_q;
  logic [7:0]  expected_id;
  logic [15:0] expected_count;

  assign step      = in_full && room;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id    <= EXPECTED_ID_RESET;
      expected_count <= EXPECTED_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_EXPECTED_ID:    expected_id    <= cfg_data[7:0];
        CFG_EXPECTED_COUNT: expected_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sbspd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .step     (step),
    .full     (in_full),
    .byte_q   (rx_q)
  );

  sbspd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .rx_q           (rx_q),
    .expected_id    (expected_id),
    .expected_count (expected_count),
    .res_valid      (res_valid),
    .res            (res)
  );

  sbspd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_q     (out_q)
  );

  assign item_kind        = out_q.item_kind;
  assign data_value       = out_q.data_value;
  assign motor_id         = out_q.motor_id;
  assign instruction_code = out_q.instruction_code;
  assign device_error     = out_q.device_error;
  assign status           = out_q.status;
  assign payload_count    = out_q.payload_count;
  assign last             = out_q.last;

endmodule

// ===== tb/servo_bus_status_packet_deframer_core_test.sv =====
`timescale 1ns / 1ps

module servo_bus_status_packet_deframer_core_test;
  import sbspd_pkg::*;

  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [3:0] {
    P_HUNT, P_ID, P_LEN_LO, P_LEN_HI, P_INSTR, P_ERR, P_DATA, P_CRC_LO, P_CRC_HI
  } parse_phase_t;

  typedef enum logic [1:0] {ESC_NONE, ESC_FF, ESC_FF_FF, ESC_FF_FF_FD} esc_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI_BAD} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic        item_kind;
  logic [7:0]  data_value;
  logic [7:0]  motor_id;
  logic [7:0]  instruction_code;
  logic [7:0]  device_error;
  logic [1:0]  status;
  logic [15:0] payload_count;
  logic        last;

  servo_bus_status_packet_deframer_core dut (.*);

  // deframer state as seen by the predictor
  parse_phase_t rx_phase;
  logic [23:0]  hunt_window;
  logic [15:0]  run_crc;
  logic [15:0]  len_field;
  logic [15:0]  raw_left;
  logic [7:0]   pkt_id;
  logic [7:0]   pkt_instr;
  logic [7:0]   pkt_err;
  esc_t         esc_state;
  logic [15:0]  unstuffed;
  logic [7:0]   crc_lo;
  logic [7:0]   cfg_id;
  logic [15:0]  cfg_count;

  result_t expected_items[$];
  int errors;
  int cycle_count;
  int bytes_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int holds_started;
  int hold_left;

  stim_row_t directed_rows [25] = '{
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hfd, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h0a, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hfd, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hfd, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{ROW_CRC_LO, 8'h00, 1'b0, NO_RESULT},
    '{ROW_CRC_HI_BAD, 8'h00, 1'b1,
      '{KIND_STATUS, 8'h00, 8'h00, 8'hff, 8'h00, STATUS_CRC_BAD, 16'd5, 1'b1}},
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hff, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hfd, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'hfe, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h03, 1'b0, NO_RESULT},
    '{ROW_BYTE, 8'h00, 1'b1,
      '{KIND_STATUS, 8'h00, 8'hfe, 8'h00, 8'h00, STATUS_SHORT, 16'd0, 1'b1}}
  };

  always #1 clk = ~clk;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic escape_step(input esc_t st, input logic [7:0] b, output esc_t nx);
    escape_step = 1'b0;
    if (st == ESC_NONE && b == SYNC_FF) nx = ESC_FF;
    else if ((st == ESC_FF || st == ESC_FF_FF) && b == SYNC_FF) nx = ESC_FF_FF;
    else if (st == ESC_FF_FF && b == SYNC_FD) nx = ESC_FF_FF_FD;
    else if (st == ESC_FF_FF_FD && b == SYNC_FD) begin
      nx = ESC_NONE;
      escape_step = 1'b1;
    end else nx = (b == SYNC_FF) ? ESC_FF : ESC_NONE;
  endfunction

  function automatic result_t frame_item(input item_kind_t kind, input logic [7:0] d,
                                         input status_t verdict);
    result_t r;
    r.item_kind = kind;
    r.data_value = d;
    r.motor_id = pkt_id;
    r.instruction_code = pkt_instr;
    r.device_error = pkt_err;
    r.status = verdict;
    r.payload_count = unstuffed;
    r.last = (kind == KIND_STATUS);
    return r;
  endfunction

  task automatic reset_model();
    cfg_id = EXPECTED_ID_RESET;
    cfg_count = EXPECTED_COUNT_RESET;
    rx_phase = P_HUNT;
    hunt_window = '0;
    run_crc = '0;
    len_field = '0;
    raw_left = '0;
    pkt_id = '0;
    pkt_instr = '0;
    pkt_err = '0;
    esc_state = ESC_NONE;
    unstuffed = '0;
    crc_lo = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, output logic hit, output result_t r);
    esc_t nx;
    logic drop;
    status_t verdict;
    hit = 1'b0;
    r = NO_RESULT;
    case (rx_phase)
      P_HUNT: begin
        if (hunt_window == SYNC_HEAD && b == SYNC_ZERO) begin
          run_crc = crc_byte(crc_byte(crc_byte(crc_byte(16'h0000, SYNC_FF), SYNC_FF),
                                      SYNC_FD), SYNC_ZERO);
          pkt_id = '0;
          pkt_instr = '0;
          pkt_err = '0;
          len_field = '0;
          raw_left = '0;
          esc_state = ESC_NONE;
          unstuffed = '0;
          crc_lo = '0;
          hunt_window = '0;
          rx_phase = P_ID;
        end else hunt_window = {hunt_window[15:0], b};
      end
      P_ID: begin
        if (cfg_id != ID_ANY && b != cfg_id) begin
          rx_phase = P_HUNT;
          hunt_window = '0;
        end else begin
          pkt_id = b;
          run_crc = crc_byte(run_crc, b);
          rx_phase = P_LEN_LO;
        end
      end
      P_LEN_LO: begin
        len_field = {8'h00, b};
        run_crc = crc_byte(run_crc, b);
        rx_phase = P_LEN_HI;
      end
      P_LEN_HI: begin
        len_field[15:8] = b;
        run_crc = crc_byte(run_crc, b);
        if (len_field < MIN_LENGTH) begin
          hit = 1'b1;
          r = frame_item(KIND_STATUS, 8'h00, STATUS_SHORT);
          rx_phase = P_HUNT;
          hunt_window = '0;
        end else begin
          raw_left = len_field - MIN_LENGTH;
          rx_phase = P_INSTR;
        end
      end
      P_INSTR: begin
        pkt_instr = b;
        run_crc = crc_byte(run_crc, b);
        rx_phase = P_ERR;
      end
      P_ERR: begin
        pkt_err = b;
        run_crc = crc_byte(run_crc, b);
        rx_phase = (raw_left == 0) ? P_CRC_LO : P_DATA;
      end
      P_DATA: begin
        run_crc = crc_byte(run_crc, b);
        drop = escape_step(esc_state, b, nx);
        esc_state = nx;
        raw_left = raw_left - 16'd1;
        if (raw_left == 0) rx_phase = P_CRC_LO;
        if (!drop) begin
          unstuffed = unstuffed + 16'd1;
          hit = 1'b1;
          r = frame_item(KIND_DATA, b, STATUS_OK);
        end
      end
      P_CRC_LO: begin
        crc_lo = b;
        rx_phase = P_CRC_HI;
      end
      P_CRC_HI: begin
        if ({b, crc_lo} != run_crc) verdict = STATUS_CRC_BAD;
        else if (unstuffed != cfg_count) verdict = STATUS_COUNT_BAD;
        else verdict = STATUS_OK;
        hit = 1'b1;
        r = frame_item(KIND_STATUS, 8'h00, verdict);
        rx_phase = P_HUNT;
        hunt_window = '0;
      end
      default: begin
        rx_phase = P_HUNT;
        hunt_window = '0;
      end
    endcase
  endtask

  // called at a falling edge, returns at a falling edge with the item taken
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
    logic hit;
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, hit, r);
    if (typed) expected_items = {expected_items, want};
    else if (hit) expected_items = {expected_items, r};
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] id_word, input logic [15:0] count_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_EXPECTED_ID;
    cfg_data <= id_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_id = id_word[7:0];
    @(negedge clk);
    cfg_index <= CFG_EXPECTED_COUNT;
    cfg_data <= count_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_count = count_word;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_packet(input int body_len);
    logic [7:0] frame[$];
    logic [7:0] body[$];
    logic [15:0] crc;
    logic [15:0] len;
    logic [7:0] b;
    esc_t st;
    esc_t nx;
    int pick;
    pick = $urandom_range(99);
    if (pick >= 90) begin
      frame = {SYNC_FF, SYNC_FF, SYNC_FD, SYNC_ZERO};
      repeat ($urandom_range(2)) frame = {frame, 8'($urandom_range(255))};
    end else if (pick >= 80) begin
      frame = {SYNC_FF, SYNC_FF, SYNC_FD};
      frame = {frame, 8'($urandom_range(255))};
    end else if (pick >= 60) begin
      repeat ($urandom_range(3, 1)) frame = {frame, 8'($urandom_range(255))};
    end
    foreach (frame[i]) send_byte(frame[i], 1'b0, NO_RESULT);
    frame = {SYNC_FF, SYNC_FF, SYNC_FD, SYNC_ZERO};
    if (cfg_id != ID_ANY && $urandom_range(99) < 85) frame = {frame, cfg_id};
    else frame = {frame, 8'($urandom_range(255))};
    if ($urandom_range(99) < 8) begin
      len = 16'($urandom_range(3));
    end else begin
      st = ESC_NONE;
      repeat (body_len) begin
        case ($urandom_range(9))
          0, 1, 2: b = SYNC_FF;
          3, 4: b = SYNC_FD;
          5: b = SYNC_ZERO;
          default: b = 8'($urandom_range(255));
        endcase
        body = {body, b};
        void'(escape_step(st, b, nx));
        st = nx;
        // stuff most escape heads, leave a few raw
        if (st == ESC_FF_FF_FD && $urandom_range(9) != 0) begin
          body = {body, SYNC_FD};
          st = ESC_NONE;
        end
      end
      len = MIN_LENGTH + 16'(body.size());
    end
    frame = {frame, len[7:0]};
    frame = {frame, len[15:8]};
    if (len >= MIN_LENGTH) begin
      frame = {frame, 8'($urandom_range(255))};
      frame = {frame, 8'($urandom_range(255))};
      frame = {frame, body};
      crc = '0;
      foreach (frame[i]) crc = crc_byte(crc, frame[i]);
      if ($urandom_range(99) < 12) crc = crc ^ (16'h0001 << $urandom_range(15));
      frame = {frame, crc[7:0]};
      frame = {frame, crc[15:8]};
    end
    foreach (frame[i]) send_byte(frame[i], 1'b0, NO_RESULT);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_items.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = expected_items.pop_front();
        check_field("item_kind", 16'(want.item_kind), 16'(item_kind));
        check_field("data_value", 16'(want.data_value), 16'(data_value));
        check_field("motor_id", 16'(want.motor_id), 16'(motor_id));
        check_field("instruction_code", 16'(want.instruction_code),
                    16'(instruction_code));
        check_field("device_error", 16'(want.device_error), 16'(device_error));
        check_field("status", 16'(want.status), 16'(status));
        check_field("payload_count", want.payload_count, payload_count);
        check_field("last", 16'(want.last), 16'(last));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_requests != holds_started) begin
      holds_started = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("servo_bus_status_packet_deframer_core test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    int start_bytes;
    int pkt;
    int body_len;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_EXPECTED_ID;
    cfg_data = '0;
    out_ready = 1'b0;
    errors = 0;
    cycle_count = 0;
    bytes_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    holds_started = 0;
    hold_left = 0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CRC_LO: b = run_crc[7:0];
        ROW_CRC_HI_BAD: b = run_crc[15:8] ^ 8'h01;
        default: b = directed_rows[i].value;
      endcase
      send_byte(b, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          1: set_config({8'($urandom_range(255)), 8'hff}, 16'hffff);
          2: set_config({8'($urandom_range(255)), 8'h00}, 16'h0000);
          3: set_config({8'($urandom_range(255)), ID_ANY}, 16'd300);
          default: set_config({8'($urandom_range(255)),
                               ($urandom_range(3) == 0) ? ID_ANY : 8'($urandom_range(255))},
                              16'($urandom_range(12)));
        endcase
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 51; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 51; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // hold the receiver off while bytes keep coming
      if (ph == 2) hold_requests++;
      start_bytes = bytes_sent;
      pkt = 0;
      while (bytes_sent - start_bytes < PHASE_BYTES) begin
        if (ph == 5 && pkt == 4) settle();
        if (ph == 3 && pkt == 0) body_len = 300;
        else if (cfg_count <= 24 && $urandom_range(9) < 7) body_len = int'(cfg_count);
        else body_len = $urandom_range(12);
        send_packet(body_len);
        pkt++;
      end
    end

    settle();
    if (errors == 0) $display("servo_bus_status_packet_deframer_core test passed");
    else $display("servo_bus_status_packet_deframer_core test failed");
    $finish;
  end

endmodule
